### rtl/dget_pkg.sv
// ----------------------------------------------------------------------------
// dget_pkg: shared types and constants of the directed graph edge table
// Table size, field widths, action and status codes, and the request,
// result and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package dget_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int SLOT_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int KEY_W        = 32;

    // action codes
    localparam logic [1:0] ACT_ADD_VERTEX  = 2'd0;
    localparam logic [1:0] ACT_ADD_EDGE    = 2'd1;
    localparam logic [1:0] ACT_REMOVE_EDGE = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_FULL         = 3'd1;
    localparam logic [2:0] ST_DUP_VERTEX   = 3'd2;
    localparam logic [2:0] ST_NO_ORIGIN    = 3'd3;
    localparam logic [2:0] ST_NO_DEST      = 3'd4;
    localparam logic [2:0] ST_DUP_EDGE     = 3'd5;
    localparam logic [2:0] ST_EDGE_MISSING = 3'd6;

    typedef struct packed {
        logic [1:0]              action;
        logic signed [KEY_W-1:0] first_key;
        logic signed [KEY_W-1:0] second_key;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  vertices_held;
        logic [3:0]  origin_slot;
        logic [15:0] origin_row;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic       load;        // latch a new request
        logic       scan_clr;    // restart the key scan at slot 0
        logic       scan_en;     // scan is running
        logic       key_sel;     // 0 compare first_key, 1 second_key
        logic       set_origin;  // take the matching slot as origin
        logic       set_new;     // store first_key at the next free slot
        logic       set_dest;    // take the matching slot as destination
        logic       edge_set;
        logic       edge_clr;
        logic       status_we;
        logic [2:0] status_code;
        logic       emit;        // register the result and strobe it
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] action;
        logic       full;
        logic       hit;
        logic       scan_end;
        logic       edge_bit;
    } stat_t;

endpackage

`default_nettype wire

### rtl/directed_graph_edge_table.sv
// ----------------------------------------------------------------------------
// directed_graph_edge_table: directed graph kept as key table and bit matrix
// Adds vertices, adds and removes edges, and reports a status, the vertex count
// and the origin vertex's slot and adjacency row for every request.
// ----------------------------------------------------------------------------
// Usage:
//   A request (action, first_key, second_key) is taken at a rising edge with
//   start high and busy low. busy stays high until the request is finished.
//   Exactly one result per request appears on result for one cycle with done
//   high; the receiver cannot stall, so sample result whenever done is high.
// Timing:
//   The key table is scanned one slot per cycle through the key memory's
//   registered read port, stopping at the first match. done is high in the
//   first cycle that busy is low, and a new request may be taken at the edge
//   that ends that cycle.
// Reset:
//   rst_n clears the vertex count and the whole adjacency matrix at once;
//   no clearing pass. Key slots above the count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module directed_graph_edge_table (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire dget_pkg::request_t request,
    output logic                    busy,
    output logic                    done,
    output dget_pkg::result_t       result
);

    // command and status links between sequencer and datapath
    dget_pkg::cmd_t  cmd;
    dget_pkg::stat_t stat;

    // sequencer: decides each step, holds nothing but its state
    dget_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // datapath: request hold, key scan, matrix and result register
    dget_dpath u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result),
        .done    (done)
    );

endmodule

`default_nettype wire

### rtl/dget_dpath.sv
// ----------------------------------------------------------------------------
// dget_dpath: key store, adjacency matrix and result register
// Holds the request, scans the key memory one slot per cycle, updates the
// adjacency matrix and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module dget_dpath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dget_pkg::request_t request,
    input  wire dget_pkg::cmd_t    cmd,
    output dget_pkg::stat_t        stat,
    output dget_pkg::result_t      result,
    output logic                   done
);

    localparam int NV = dget_pkg::MAX_VERTICES;
    localparam int SW = dget_pkg::SLOT_W;
    localparam int CW = dget_pkg::CNT_W;

    dget_pkg::request_t     req_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          scan_reg;
    logic [SW-1:0]          cmp_slot_reg;
    logic                   cmp_pend_reg;
    logic [SW-1:0]          slot_reg;
    logic                   slot_valid_reg;
    logic [SW-1:0]          dest_reg;
    logic [2:0]             status_reg;
    logic [NV-1:0]          adj_reg [NV];
    logic [dget_pkg::KEY_W-1:0] key_mem [NV];
    logic [dget_pkg::KEY_W-1:0] rdata_reg;
    dget_pkg::result_t      result_reg;
    logic                   done_reg;

    logic [dget_pkg::KEY_W-1:0] key;
    logic                   hit;
    logic                   scan_end;
    logic                   step;
    logic [SW-1:0]          new_slot;

    assign key      = cmd.key_sel ? req_reg.second_key : req_reg.first_key;
    assign hit      = cmp_pend_reg && (rdata_reg == key);
    assign scan_end = (scan_reg >= count_reg);
    assign step     = cmd.scan_en && !cmd.scan_clr && !hit && !scan_end;
    assign new_slot = count_reg[SW-1:0];

    assign stat.action   = req_reg.action;
    assign stat.full     = (count_reg == CW'(NV));
    assign stat.hit      = hit;
    assign stat.scan_end = scan_end;
    assign stat.edge_bit = adj_reg[slot_reg][dest_reg];

    assign result = result_reg;
    assign done   = done_reg;

    // key memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.set_new)
        begin
            key_mem[new_slot] <= req_reg.first_key;
        end
        rdata_reg <= key_mem[scan_reg[SW-1:0]];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        if (step)
        begin
            cmp_slot_reg <= scan_reg[SW-1:0];
        end
        if (cmd.set_origin)
        begin
            slot_reg <= cmp_slot_reg;
        end
        else if (cmd.set_new)
        begin
            slot_reg <= new_slot;
        end
        if (cmd.set_dest)
        begin
            dest_reg <= cmp_slot_reg;
        end
        if (cmd.load)
        begin
            status_reg <= dget_pkg::ST_OK;
        end
        else if (cmd.status_we)
        begin
            status_reg <= cmd.status_code;
        end
        if (cmd.emit)
        begin
            result_reg.status        <= status_reg;
            result_reg.vertices_held <= 5'(count_reg);
            result_reg.origin_slot   <= slot_valid_reg ? 4'(slot_reg) : 4'd0;
            result_reg.origin_row    <= slot_valid_reg ? 16'(adj_reg[slot_reg]) : 16'd0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            scan_reg       <= '0;
            cmp_pend_reg   <= 1'b0;
            slot_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
            for (int i = 0; i < NV; i++)
            begin
                adj_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cmd.scan_clr)
            begin
                scan_reg     <= '0;
                cmp_pend_reg <= 1'b0;
            end
            else
            begin
                cmp_pend_reg <= step;
                if (step)
                begin
                    scan_reg <= scan_reg + CW'(1);
                end
            end
            if (cmd.load)
            begin
                slot_valid_reg <= 1'b0;
            end
            else if (cmd.set_origin || cmd.set_new)
            begin
                slot_valid_reg <= 1'b1;
            end
            if (cmd.set_new)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.edge_set)
            begin
                adj_reg[slot_reg][dest_reg] <= 1'b1;
            end
            else if (cmd.edge_clr)
            begin
                adj_reg[slot_reg][dest_reg] <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(NV))
        else $error("vertex count beyond table size");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + CW'(1)))
        else $error("vertex count moved by other than one");

    a_edge_written: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.edge_set |=> adj_reg[$past(slot_reg)][$past(dest_reg)])
        else $error("edge bit not set after add edge");

    a_no_origin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (result_reg.status == dget_pkg::ST_NO_ORIGIN
                      || result_reg.status == dget_pkg::ST_FULL))
        |-> (result_reg.origin_slot == 4'd0 && result_reg.origin_row == 16'd0))
        else $error("nonzero slot or row reported without an origin");
`endif

endmodule

`default_nettype wire

### rtl/dget_ctrl.sv
// ----------------------------------------------------------------------------
// dget_ctrl: sequencer of the directed graph edge table
// Walks each request through dispatch and, as its action and outcome need,
// origin scan, destination scan and matrix update, then result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module dget_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire dget_pkg::stat_t stat,
    output dget_pkg::cmd_t      cmd,
    output logic                busy
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DISPATCH = 6'b000010,
        S_SCAN_A   = 6'b000100,
        S_SCAN_B   = 6'b001000,
        S_EDGE     = 6'b010000,
        S_EMIT     = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.action)
                    dget_pkg::ACT_ADD_VERTEX:
                    begin
                        if (stat.full)
                        begin
                            cmd.status_we   = 1'b1;
                            cmd.status_code = dget_pkg::ST_FULL;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            cmd.scan_clr = 1'b1;
                            state_next   = S_SCAN_A;
                        end
                    end
                    dget_pkg::ACT_ADD_EDGE,
                    dget_pkg::ACT_REMOVE_EDGE:
                    begin
                        cmd.scan_clr = 1'b1;
                        state_next   = S_SCAN_A;
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_SCAN_A:
            begin
                cmd.scan_en = 1'b1;
                if (stat.hit)
                begin
                    cmd.set_origin = 1'b1;
                    if (stat.action == dget_pkg::ACT_ADD_VERTEX)
                    begin
                        cmd.status_we   = 1'b1;
                        cmd.status_code = dget_pkg::ST_DUP_VERTEX;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        cmd.scan_clr = 1'b1;
                        state_next   = S_SCAN_B;
                    end
                end
                else if (stat.scan_end)
                begin
                    if (stat.action == dget_pkg::ACT_ADD_VERTEX)
                    begin
                        cmd.set_new = 1'b1;
                    end
                    else
                    begin
                        cmd.status_we   = 1'b1;
                        cmd.status_code = dget_pkg::ST_NO_ORIGIN;
                    end
                    state_next = S_EMIT;
                end
            end
            S_SCAN_B:
            begin
                cmd.scan_en = 1'b1;
                cmd.key_sel = 1'b1;
                if (stat.hit)
                begin
                    cmd.set_dest = 1'b1;
                    state_next   = S_EDGE;
                end
                else if (stat.scan_end)
                begin
                    cmd.status_we   = 1'b1;
                    cmd.status_code = dget_pkg::ST_NO_DEST;
                    state_next      = S_EMIT;
                end
            end
            S_EDGE:
            begin
                if (stat.action == dget_pkg::ACT_ADD_EDGE)
                begin
                    if (stat.edge_bit)
                    begin
                        cmd.status_we   = 1'b1;
                        cmd.status_code = dget_pkg::ST_DUP_EDGE;
                    end
                    else
                    begin
                        cmd.edge_set = 1'b1;
                    end
                end
                else
                begin
                    if (stat.edge_bit)
                    begin
                        cmd.edge_clr = 1'b1;
                    end
                    else
                    begin
                        cmd.status_we   = 1'b1;
                        cmd.status_code = dget_pkg::ST_EDGE_MISSING;
                    end
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire
